// File: hdl/twmh_pkg.sv
// Shared types and constants for the timed work min-heap.
// Holds the word formats of both channels, command and status codes.
// No dependencies.
package twmh_pkg;

	localparam int ID_BITS   = 8;
	localparam int TIME_BITS = 32;
	localparam int CNT_W     = 5;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	localparam logic [CMD_W-1:0] CMD_SCHED    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd2;
	localparam logic [STAT_W-1:0] ST_WAIT = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [ID_BITS-1:0]   item_id;
		logic [TIME_BITS-1:0] due_time;
		logic [TIME_BITS-1:0] now_tick;
	} in_word_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [ID_BITS-1:0]   out_id;
		logic [TIME_BITS-1:0] out_time;
		logic [CNT_W-1:0]     count;
	} out_word_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [TIME_BITS-1:0] tm;
	} entry_t;

endpackage

// File: hdl/twmh_ram.sv
// Heap entry store: one write port, one read port with registered data.
// Depends on twmh_pkg.
module twmh_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  twmh_pkg::entry_t  wdata,
	input  logic [AW-1:0]     raddr,
	output twmh_pkg::entry_t  rdata
);
	import twmh_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/twmh_seq.sv
// Heap sequencer: scan, move, append and sift-down over the entry store.
// Depends on twmh_pkg and twmh_ram.
module twmh_seq #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  twmh_pkg::in_word_t          req,
	input  logic [twmh_pkg::CNT_W-1:0]  usable,
	output logic                        busy,
	output logic                        res_valid,
	input  logic                        res_take,
	output twmh_pkg::out_word_t         res
);
	import twmh_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CK, S_HEAD_RD, S_HEAD_CK, S_MV_RD, S_MV_WR,
		S_SCHED, S_REB, S_SD_N, S_SD_L, S_SD_R, S_SD_C, S_SD_W2, S_DONE
	} state_t;

	state_t               state_q;
	in_word_t             req_q;
	logic [CNT_W-1:0]     held_q, idx_q, node_q, reb_q, best_q;
	logic                 appended_q;
	entry_t               node_ent_q, lft_ent_q;
	logic [STAT_W-1:0]    status_q;
	logic [ID_BITS-1:0]   oid_q;
	logic [TIME_BITS-1:0] otime_q;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	entry_t           wdata, rdata;
	logic [CNT_W:0]   l_w, r_w;
	logic             l_ok, r_ok;
	logic [CNT_W-1:0] best_idx;
	entry_t           best_ent;
	logic             full;
	logic [CNT_W-1:0] held_dec, held_inc;

	twmh_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign l_w      = {node_q, 1'b1};
	assign r_w      = l_w + (CNT_W+1)'(1);
	assign l_ok     = l_w < {1'b0, held_q};
	assign r_ok     = r_w < {1'b0, held_q};
	assign full     = held_q >= usable;
	assign held_dec = held_q - CNT_W'(1);
	assign held_inc = held_q + CNT_W'(1);

	// smaller child wins, left wins ties, parent stays unless strictly larger
	always_comb begin
		best_idx = node_q;
		best_ent = node_ent_q;
		if (l_ok) begin
			if (lft_ent_q.tm < best_ent.tm) begin
				best_idx = CNT_W'(l_w);
				best_ent = lft_ent_q;
			end
		end
		if (r_ok) begin
			if (rdata.tm < best_ent.tm) begin
				best_idx = CNT_W'(r_w);
				best_ent = rdata;
			end
		end
	end

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = rdata;
		unique case (state_q)
			S_SCAN_RD: raddr = AW'(idx_q);
			S_MV_RD:   raddr = AW'(held_dec);
			S_SD_N:    raddr = AW'(node_q);
			S_SD_L:    raddr = AW'(l_w);
			S_SD_R:    raddr = AW'(r_w);
			S_MV_WR: begin
				we    = 1'b1;
				waddr = AW'(idx_q);
				wdata = rdata;
			end
			S_SCHED: begin
				we    = !full;
				waddr = AW'(held_q);
				wdata = '{id: req_q.item_id, tm: req_q.due_time};
			end
			S_SD_C: begin
				we    = best_idx != node_q;
				waddr = AW'(node_q);
				wdata = best_ent;
			end
			S_SD_W2: begin
				we    = 1'b1;
				waddr = AW'(best_q);
				wdata = node_ent_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			held_q     <= '0;
			req_q      <= '0;
			idx_q      <= '0;
			node_q     <= '0;
			reb_q      <= '0;
			best_q     <= '0;
			appended_q <= 1'b0;
			node_ent_q <= '0;
			lft_ent_q  <= '0;
			status_q   <= ST_MISS;
			oid_q      <= '0;
			otime_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q      <= req;
						status_q   <= ST_MISS;
						oid_q      <= '0;
						otime_q    <= '0;
						appended_q <= 1'b0;
						idx_q      <= '0;
						case (req.command)
							CMD_SCHED, CMD_CANCEL: state_q <= S_SCAN_RD;
							CMD_DISPATCH: state_q <= (held_q == '0) ? S_DONE : S_HEAD_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN_RD: begin
					if (idx_q >= held_q) begin
						state_q <= (req_q.command == CMD_SCHED) ? S_SCHED : S_DONE;
					end else begin
						state_q <= S_SCAN_CK;
					end
				end
				S_SCAN_CK: begin
					if (rdata.id == req_q.item_id) begin
						status_q <= ST_OK;
						state_q  <= S_MV_RD;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_HEAD_RD: state_q <= S_HEAD_CK;
				S_HEAD_CK: begin
					otime_q <= rdata.tm;
					if (rdata.tm > req_q.now_tick) begin
						status_q <= ST_WAIT;
						state_q  <= S_DONE;
					end else begin
						status_q <= ST_OK;
						oid_q    <= rdata.id;
						idx_q    <= '0;
						state_q  <= S_MV_RD;
					end
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					held_q  <= held_dec;
					reb_q   <= held_dec >> 1;
					state_q <= S_REB;
				end
				S_SCHED: begin
					if (full) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						held_q     <= held_inc;
						reb_q      <= held_inc >> 1;
						appended_q <= 1'b1;
						status_q   <= ST_OK;
						state_q    <= S_REB;
					end
				end
				S_REB: begin
					if (reb_q == '0) begin
						if (req_q.command == CMD_SCHED && !appended_q) begin
							state_q <= S_SCHED;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						reb_q   <= reb_q - CNT_W'(1);
						node_q  <= reb_q - CNT_W'(1);
						state_q <= S_SD_N;
					end
				end
				S_SD_N: state_q <= S_SD_L;
				S_SD_L: begin
					node_ent_q <= rdata;
					state_q    <= S_SD_R;
				end
				S_SD_R: begin
					lft_ent_q <= rdata;
					state_q   <= S_SD_C;
				end
				S_SD_C: begin
					if (best_idx != node_q) begin
						best_q  <= best_idx;
						state_q <= S_SD_W2;
					end else begin
						state_q <= S_REB;
					end
				end
				S_SD_W2: begin
					node_q  <= best_q;
					state_q <= S_SD_N;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign res_valid  = state_q == S_DONE;
	assign res.status   = status_q;
	assign res.out_id   = oid_q;
	assign res.out_time = otime_q;
	assign res.count    = held_q;

endmodule

// File: hdl/timed_work_min_heap.sv
// Top level of the timed work min-heap: capacity register, input capture,
// output word register. Depends on twmh_pkg and twmh_seq.
//
//  channel  | handshake             | word
//  ---------+-----------------------+-------------------------------
//  in       | in_valid / in_stall   | in_word  (command, id, times)
//  out      | out_valid / out_stall | out_word (status, id, time, count)
//  cfg      | cfg_we                | cfg_data (capacity)
//
// One word at a time. The shortest word is an empty dispatch or an unknown
// command; the worst case at N = 15 is a reschedule of the last held id
// (id scan, move, two rebuilds of node checks and sift swaps), and the
// single read port of the entry store sets the pace. in_stall stays high
// while a word is worked on.
// A finished result waits in the output register, so the next word can
// start while out_stall holds the previous one. Reset clears the count and sets
// the capacity back to 16; entry contents need no clearing.
module timed_work_min_heap #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  twmh_pkg::in_word_t          in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output twmh_pkg::out_word_t         out_word,
	input  logic                        cfg_we,
	input  logic [twmh_pkg::CNT_W-1:0]  cfg_data
);
	import twmh_pkg::*;

	logic [CNT_W-1:0] capacity_q;
	logic [8:0]       cap_w;
	logic [CNT_W-1:0] usable;
	logic             busy, start;
	logic             res_valid, res_take;
	out_word_t        res;
	logic             out_valid_q;
	out_word_t        out_word_q;

	// hold the capacity register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// clamp to the store depth, keep one slot in reserve
	always_comb begin
		cap_w = {4'b0, capacity_q};
		if (cap_w > 9'(QUEUE_DEPTH)) begin
			cap_w = 9'(QUEUE_DEPTH);
		end
		usable = (cap_w == '0) ? '0 : CNT_W'(cap_w - 9'd1);
	end

	assign in_stall = busy;
	assign start    = in_valid && !busy;

	twmh_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (in_word),
		.usable    (usable),
		.busy      (busy),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// advance the result into the output register once it is free
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			out_word_q  <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// File: hdl/twmh_chk.sv
// Port-level checks for the timed work min-heap, bound to the top level.
// Depends on twmh_pkg.
module twmh_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input twmh_pkg::out_word_t out_word
);
	import twmh_pkg::*;

	// an accepted word always keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took a word and was not busy");

	// only a successful dispatch returns an id
	a_id_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != ST_OK |-> out_word.out_id == '0)
		else $error("id returned without success");

	// a full report never carries a time
	a_full_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == ST_FULL |-> out_word.out_time == '0)
		else $error("full report carries a time");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

endmodule

bind timed_work_min_heap twmh_chk u_chk (.*);

// File: sim/timed_work_min_heap_test.sv
// Self-checking bench for the timed work min-heap: directed and random command
// sequences checked word by word against an in-bench heap predictor.
// Depends on twmh_pkg and the timed_work_min_heap RTL.
module timed_work_min_heap_test;
	timeunit 1ns;
	timeprecision 1ps;
	import twmh_pkg::*;

	localparam int DEPTH = 16;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;
	logic        cfg_we;
	logic [CNT_W-1:0] cfg_data;

	timed_work_min_heap #(.QUEUE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Predictor state: a private copy of the heap and the capacity register.
	logic [ID_BITS-1:0]   heap_id [DEPTH];
	logic [TIME_BITS-1:0] heap_tm [DEPTH];
	int unsigned          held;
	logic [CNT_W-1:0]     cap_reg;

	out_word_t result_queue[$];
	int        mismatches;
	int        results_seen;
	int        words_sent;
	logic      stall_random;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop far beyond the slowest legal run of about 1600 words.
	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void swap_entries(int unsigned a, int unsigned b);
		logic [ID_BITS-1:0]   ti;
		logic [TIME_BITS-1:0] tt;
		ti = heap_id[a]; heap_id[a] = heap_id[b]; heap_id[b] = ti;
		tt = heap_tm[a]; heap_tm[a] = heap_tm[b]; heap_tm[b] = tt;
	endfunction

	// Sift down one node; the left child wins ties, parents move only on strict less.
	function automatic void sift_node(int unsigned node);
		int unsigned best, l, r;
		while (held > 1) begin
			best = node;
			l = 2 * node + 1;
			r = 2 * node + 2;
			if (l < held && heap_tm[l] < heap_tm[best]) best = l;
			if (r < held && heap_tm[r] < heap_tm[best]) best = r;
			if (best == node) return;
			swap_entries(node, best);
			node = best;
		end
	endfunction

	function automatic void heapify();
		for (int i = int'(held / 2) - 1; i >= 0; i--) sift_node(i);
	endfunction

	function automatic bit drop_id(logic [ID_BITS-1:0] id);
		for (int unsigned i = 0; i < held; i++) begin
			if (heap_id[i] == id) begin
				swap_entries(i, held - 1);
				held--;
				heapify();
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Compute the result word one command produces and advance the model.
	function automatic out_word_t predict_heap_op(in_word_t w);
		out_word_t   r;
		int unsigned usable, capv;
		r = '0;
		r.status = ST_MISS;
		case (w.command)
			CMD_SCHED: begin
				capv = (cap_reg > DEPTH) ? DEPTH : cap_reg;
				usable = (capv > 0) ? capv - 1 : 0;
				void'(drop_id(w.item_id));
				if (held >= usable) begin
					r.status = ST_FULL;
				end else begin
					heap_id[held] = w.item_id;
					heap_tm[held] = w.due_time;
					held++;
					heapify();
					r.status = ST_OK;
				end
			end
			CMD_CANCEL: begin
				r.status = drop_id(w.item_id) ? ST_OK : ST_MISS;
			end
			CMD_DISPATCH: begin
				if (held == 0) begin
					r.status = ST_MISS;
				end else if (heap_tm[0] > w.now_tick) begin
					r.status = ST_WAIT;
					r.out_time = heap_tm[0];
				end else begin
					r.out_id = heap_id[0];
					r.out_time = heap_tm[0];
					swap_entries(0, held - 1);
					held--;
					heapify();
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(held);
		return r;
	endfunction

	// Receiver: after each accepted word stall for a drawn number of cycles,
	// check every accepted word against the oldest expectation.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				out_word_t exp_w;
				results_seen++;
				if (result_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %p", out_word);
				end else begin
					exp_w = result_queue.pop_front();
					if (out_word.status !== exp_w.status || out_word.out_id !== exp_w.out_id
						|| out_word.out_time !== exp_w.out_time
						|| out_word.count !== exp_w.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected st=%0d id=%0d t=%0d n=%0d, got st=%0d id=%0d t=%0d n=%0d",
								exp_w.status, exp_w.out_id, exp_w.out_time, exp_w.count,
								out_word.status, out_word.out_id, out_word.out_time,
								out_word.count);
					end
				end
				// Hold off the next word for a drawn number of cycles.
				stall_left = stall_random ? $urandom_range(0, 4) : 0;
				out_stall <= (stall_left != 0);
			end else if (out_stall) begin
				if (stall_left > 0) stall_left--;
				if (stall_left == 0) out_stall <= 1'b0;
			end
		end
	end

	// Send one word: draw an idle gap, raise valid, hold it until accepted.
	// Valid stays high after acceptance; a gap before the next word or wait_idle drops it.
	task automatic send_word(logic [1:0] cmd, logic [ID_BITS-1:0] id,
		logic [TIME_BITS-1:0] due, logic [TIME_BITS-1:0] now);
		in_word_t    w;
		int unsigned gap;
		w.command = cmd;
		w.item_id = id;
		w.due_time = due;
		w.now_tick = now;
		gap = stall_random ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		result_queue.push_back(predict_heap_op(w));
		words_sent++;
	endtask

	// Drain all expectations, then let the block settle before touching the register.
	task automatic wait_idle();
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		while (result_queue.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (400) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
	endtask

	task automatic test_directed();
		send_word(CMD_DISPATCH, 8'd0, 32'd0, 32'd0);            // dispatch on empty
		send_word(CMD_CANCEL, 8'd7, 32'd0, 32'd0);              // cancel of absent id
		send_word(CMD_SCHED, 8'hFF, 32'hFFFF_FFFF, 32'd0);
		send_word(CMD_SCHED, 8'h00, 32'd0, 32'hFFFF_FFFF);
		send_word(CMD_SCHED, 8'h55, 32'd100, 32'd0);
		send_word(CMD_SCHED, 8'hAA, 32'd100, 32'd0);            // tie on time
		send_word(CMD_SCHED, 8'h55, 32'd50, 32'd0);             // reschedule held id
		send_word(CMD_DISPATCH, 8'd0, 32'd0, 32'd10);           // head due at time 0, dispatched
		send_word(CMD_DISPATCH, 8'd0, 32'd0, 32'hFFFF_FFFF);
		send_word(CMD_CANCEL, 8'hFF, 32'd0, 32'd0);
		send_word(2'd3, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unknown command
		for (int i = 0; i < 16; i++)                           // fill past capacity
			send_word(CMD_SCHED, 8'(i + 16), 32'($urandom_range(0, 50)), 32'd0);
	endtask

	// Mostly well-formed traffic on a small id pool so cancels and reschedules hit.
	task automatic test_random(int unsigned n);
		int unsigned sel;
		logic [TIME_BITS-1:0] base;
		for (int unsigned i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			base = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1000));
			if (sel < 45)
				send_word(CMD_SCHED, $urandom_range(0, 3) == 0 ? 8'($urandom) :
					8'($urandom_range(0, 20)), base, $urandom);
			else if (sel < 65)
				send_word(CMD_CANCEL, $urandom_range(0, 3) == 0 ? 8'($urandom) :
					8'($urandom_range(0, 20)), $urandom, $urandom);
			else if (sel < 97)
				send_word(CMD_DISPATCH, 8'($urandom), $urandom,
					$urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1000)));
			else
				send_word(2'd3, 8'($urandom), $urandom, $urandom);
		end
	endtask

	task automatic test_capacity_sweep();
		logic [CNT_W-1:0] caps[6] = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd5, 5'd16};
		foreach (caps[k]) begin
			write_capacity(caps[k]);
			test_random(120);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		held = 0;
		cap_reg = CAP_RESET;
		mismatches = 0;
		results_seen = 0;
		words_sent = 0;
		stall_random = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		stall_random = 1'b1;
		test_random(400);
		wait_idle();                  // sender pauses until every result is back
		test_capacity_sweep();
		stall_random = 1'b0;
		test_random(100);             // back-to-back stretch
		stall_random = 1'b1;
		write_capacity(5'd16);
		test_random(300);
		wait_idle();

		if (result_queue.size() != 0) mismatches += result_queue.size();
		$display("covered %0d words, %0d results, capacities 0,1,2,5,16,31 with random stalls",
			words_sent, results_seen);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
